FILE: hdl/fsha_pkg.sv
// types, codes and constant tables shared by the fan speed and humidity alarm regulator
// used by fsha_cfg_regs, fsha_step and the top level core; no dependencies
package fsha_pkg;

  // action mode, one-hot
  typedef enum logic [3:0] {
    MODE_DISP = 4'b0001,
    MODE_FAN  = 4'b0010,
    MODE_BUZ  = 4'b0100,
    MODE_ADJ  = 4'b1000
  } mode_e;

  // reported mode codes
  localparam logic [2:0] MODE_OUT_NORMAL = 3'd0;
  localparam logic [2:0] MODE_OUT_DEBUG  = 3'd1;
  localparam logic [2:0] MODE_OUT_FAN    = 3'd2;
  localparam logic [2:0] MODE_OUT_BUZ    = 3'd3;
  localparam logic [2:0] MODE_OUT_ADJ    = 3'd4;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_KEY    = 1'b1;

  // key codes
  localparam logic [3:0] KEY_1 = 4'd1;
  localparam logic [3:0] KEY_2 = 4'd2;
  localparam logic [3:0] KEY_3 = 4'd3;
  localparam logic [3:0] KEY_4 = 4'd4;
  localparam logic [3:0] KEY_5 = 4'd5;
  localparam logic [3:0] KEY_6 = 4'd6;
  localparam logic [3:0] KEY_7 = 4'd7;
  localparam logic [3:0] KEY_8 = 4'd8;

  // configuration register indexes
  localparam logic [2:0] REG_HUM_LOW_FLOOR    = 3'd0;
  localparam logic [2:0] REG_HUM_LOW_CEILING  = 3'd1;
  localparam logic [2:0] REG_HUM_HIGH_FLOOR   = 3'd2;
  localparam logic [2:0] REG_HUM_HIGH_CEILING = 3'd3;
  localparam logic [2:0] REG_TEMP_FLOOR       = 3'd4;
  localparam logic [2:0] REG_TEMP_CEILING     = 3'd5;
  localparam logic [2:0] REG_HUM_STEP_SIZE    = 3'd6;
  localparam logic [2:0] REG_TEMP_STEP_SIZE   = 3'd7;

  localparam logic [7:0] DUTY_FULL = 8'd255;
  localparam logic [7:0] FAN_WINDOW = 8'd4;

  typedef struct packed {
    logic [7:0] hum_low_floor;
    logic [7:0] hum_low_ceiling;
    logic [7:0] hum_high_floor;
    logic [7:0] hum_high_ceiling;
    logic [7:0] temp_floor;
    logic [7:0] temp_ceiling;
    logic [5:0] hum_step_size;
    logic [4:0] temp_step_size;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] temperature;
    logic [6:0] humidity;
    logic       sensor_fault;
    logic [3:0] key;
  } item_t;

  typedef struct packed {
    mode_e      mode;
    logic       dbg;
    logic [7:0] hum_low;
    logic [7:0] hum_high;
    logic [7:0] temp_start;
    logic [7:0] duty;
    logic [6:0] pct;
  } state_t;

  typedef struct packed {
    logic [7:0] temp_start_now;
    logic [7:0] hum_high_now;
    logic [7:0] hum_low_now;
    logic [2:0] mode_now;
    logic       buzzer_on;
    logic [6:0] fan_percent;
    logic [7:0] fan_duty;
  } result_t;

  // fan level 0..5 to percent (steps of 20)
  function automatic logic [6:0] level_pct(input logic [2:0] lvl);
    logic [6:0] p;
    case (lvl)
      3'd0:    p = 7'd0;
      3'd1:    p = 7'd20;
      3'd2:    p = 7'd40;
      3'd3:    p = 7'd60;
      3'd4:    p = 7'd80;
      default: p = 7'd100;
    endcase
    return p;
  endfunction

  // fan level 0..5 to duty, percent*255/100
  function automatic logic [7:0] level_duty(input logic [2:0] lvl);
    logic [7:0] d;
    case (lvl)
      3'd0:    d = 8'd0;
      3'd1:    d = 8'd51;
      3'd2:    d = 8'd102;
      3'd3:    d = 8'd153;
      3'd4:    d = 8'd204;
      default: d = 8'd255;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/fsha_cfg_regs.sv
// configuration register file of the regulator: threshold bounds and step sizes
// depends on fsha_pkg
module fsha_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [2:0]        wr_index_i,
  input  logic [7:0]        wr_data_i,
  output fsha_pkg::cfg_t    cfg_o
);

  fsha_pkg::cfg_t cfg_q, cfg_d;

  // decode one register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        fsha_pkg::REG_HUM_LOW_FLOOR:    cfg_d.hum_low_floor    = wr_data_i;
        fsha_pkg::REG_HUM_LOW_CEILING:  cfg_d.hum_low_ceiling  = wr_data_i;
        fsha_pkg::REG_HUM_HIGH_FLOOR:   cfg_d.hum_high_floor   = wr_data_i;
        fsha_pkg::REG_HUM_HIGH_CEILING: cfg_d.hum_high_ceiling = wr_data_i;
        fsha_pkg::REG_TEMP_FLOOR:       cfg_d.temp_floor       = wr_data_i;
        fsha_pkg::REG_TEMP_CEILING:     cfg_d.temp_ceiling     = wr_data_i;
        fsha_pkg::REG_HUM_STEP_SIZE:    cfg_d.hum_step_size    = wr_data_i[5:0];
        fsha_pkg::REG_TEMP_STEP_SIZE:   cfg_d.temp_step_size   = wr_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hum_low_floor    <= 8'd10;
      cfg_q.hum_low_ceiling  <= 8'd60;
      cfg_q.hum_high_floor   <= 8'd50;
      cfg_q.hum_high_ceiling <= 8'd90;
      cfg_q.temp_floor       <= 8'd15;
      cfg_q.temp_ceiling     <= 8'd35;
      cfg_q.hum_step_size    <= 6'd5;
      cfg_q.temp_step_size   <= 5'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/fsha_step.sv
// combinational next-state and result logic for one sample or key transaction
// depends on fsha_pkg
module fsha_step #(
  parameter int unsigned DEFAULT_HUM_LOW    = 40,
  parameter int unsigned DEFAULT_HUM_HIGH   = 70,
  parameter int unsigned DEFAULT_TEMP_START = 25
) (
  input  fsha_pkg::cfg_t    cfg_i,
  input  fsha_pkg::state_t  state_i,
  input  fsha_pkg::item_t   item_i,
  output fsha_pkg::state_t  state_o,
  output fsha_pkg::result_t result_o
);

  fsha_pkg::state_t s;
  logic             buzz;
  logic [8:0]       win_top;
  logic [7:0]       t_diff;
  logic [2:0]       lvl;
  logic [2:0]       mode_out;

  // fan level from temperature and start threshold
  always_comb begin
    win_top = {1'b0, state_i.temp_start} + {1'b0, fsha_pkg::FAN_WINDOW};
    t_diff  = item_i.temperature - state_i.temp_start;
    if (item_i.temperature < state_i.temp_start) begin
      lvl = 3'd0;
    end else if ({1'b0, item_i.temperature} >= win_top) begin
      lvl = 3'd5;
    end else begin
      lvl = t_diff[2:0] + 3'd1;
    end
  end

  // state update
  always_comb begin
    s    = state_i;
    buzz = 1'b0;
    if (item_i.command == fsha_pkg::CMD_KEY) begin
      if (state_i.mode == fsha_pkg::MODE_ADJ) begin
        // threshold adjust keys, default restore (key 4) and exit to display (key 8)
        case (item_i.key)
          fsha_pkg::KEY_1: if (state_i.hum_low < cfg_i.hum_low_ceiling)
            s.hum_low = state_i.hum_low + {2'b0, cfg_i.hum_step_size};
          fsha_pkg::KEY_5: if (state_i.hum_low > cfg_i.hum_low_floor)
            s.hum_low = state_i.hum_low - {2'b0, cfg_i.hum_step_size};
          fsha_pkg::KEY_2: if (state_i.hum_high < cfg_i.hum_high_ceiling)
            s.hum_high = state_i.hum_high + {2'b0, cfg_i.hum_step_size};
          fsha_pkg::KEY_6: if (state_i.hum_high > cfg_i.hum_high_floor)
            s.hum_high = state_i.hum_high - {2'b0, cfg_i.hum_step_size};
          fsha_pkg::KEY_3: if (state_i.temp_start < cfg_i.temp_ceiling)
            s.temp_start = state_i.temp_start + {3'b0, cfg_i.temp_step_size};
          fsha_pkg::KEY_7: if (state_i.temp_start > cfg_i.temp_floor)
            s.temp_start = state_i.temp_start - {3'b0, cfg_i.temp_step_size};
          fsha_pkg::KEY_4: begin
            s.hum_low    = 8'(DEFAULT_HUM_LOW);
            s.hum_high   = 8'(DEFAULT_HUM_HIGH);
            s.temp_start = 8'(DEFAULT_TEMP_START);
          end
          fsha_pkg::KEY_8: begin
            s.mode = fsha_pkg::MODE_DISP;
            s.dbg  = 1'b0;
            s.duty = 8'd0;
            s.pct  = 7'd0;
          end
          default: ;
        endcase
      end else begin
        // mode keys
        case (item_i.key)
          fsha_pkg::KEY_1, fsha_pkg::KEY_2: begin
            s.mode = fsha_pkg::MODE_DISP;
            s.dbg  = 1'b0;
            s.duty = 8'd0;
            s.pct  = 7'd0;
          end
          fsha_pkg::KEY_3: begin
            s.pct = 7'd0;
            if (state_i.mode == fsha_pkg::MODE_DISP || state_i.mode == fsha_pkg::MODE_BUZ) begin
              s.mode = fsha_pkg::MODE_FAN;
              s.duty = fsha_pkg::DUTY_FULL;
            end else begin
              s.mode = fsha_pkg::MODE_DISP;
            end
          end
          fsha_pkg::KEY_4: begin
            s.pct = 7'd0;
            if (state_i.mode == fsha_pkg::MODE_DISP || state_i.mode == fsha_pkg::MODE_FAN) begin
              s.mode = fsha_pkg::MODE_BUZ;
              s.duty = 8'd0;
            end else begin
              s.mode = fsha_pkg::MODE_DISP;
            end
          end
          fsha_pkg::KEY_5: begin
            s.dbg  = !state_i.dbg;
            s.mode = fsha_pkg::MODE_DISP;
            s.duty = 8'd0;
            s.pct  = 7'd0;
          end
          fsha_pkg::KEY_6: begin
            s.dbg  = 1'b0;
            s.mode = fsha_pkg::MODE_ADJ;
            s.duty = 8'd0;
            s.pct  = 7'd0;
          end
          default: ;
        endcase
      end
      buzz = (s.mode == fsha_pkg::MODE_BUZ);
    end else begin
      // sensor sample
      case (state_i.mode)
        fsha_pkg::MODE_DISP: begin
          if (!state_i.dbg) begin
            if (item_i.sensor_fault) begin
              s.duty = 8'd0;
              s.pct  = 7'd0;
            end else begin
              buzz   = ({1'b0, item_i.humidity} <= state_i.hum_low) ||
                       ({1'b0, item_i.humidity} >= state_i.hum_high);
              s.pct  = fsha_pkg::level_pct(lvl);
              s.duty = fsha_pkg::level_duty(lvl);
            end
          end
        end
        fsha_pkg::MODE_FAN: s.duty = fsha_pkg::DUTY_FULL;
        fsha_pkg::MODE_BUZ: begin
          s.duty = 8'd0;
          buzz   = 1'b1;
        end
        default: s.duty = 8'd0;
      endcase
    end
  end

  // reported mode code
  always_comb begin
    case (s.mode)
      fsha_pkg::MODE_DISP: mode_out = s.dbg ? fsha_pkg::MODE_OUT_DEBUG
                                            : fsha_pkg::MODE_OUT_NORMAL;
      fsha_pkg::MODE_FAN:  mode_out = fsha_pkg::MODE_OUT_FAN;
      fsha_pkg::MODE_BUZ:  mode_out = fsha_pkg::MODE_OUT_BUZ;
      default:             mode_out = fsha_pkg::MODE_OUT_ADJ;
    endcase
  end

  assign state_o = s;

  always_comb begin
    result_o.fan_duty       = s.duty;
    result_o.fan_percent    = (mode_out == fsha_pkg::MODE_OUT_NORMAL) ? s.pct : 7'd0;
    result_o.buzzer_on      = buzz;
    result_o.mode_now       = mode_out;
    result_o.hum_low_now    = s.hum_low;
    result_o.hum_high_now   = s.hum_high;
    result_o.temp_start_now = s.temp_start;
  end

endmodule

FILE: hdl/fan_speed_and_humidity_alarm_regulator_core.sv
// top level of the fan speed and humidity alarm regulator: stream ports and pipeline
// depends on fsha_pkg, fsha_cfg_regs and fsha_step

// Each input transaction is a sensor sample (tuser 0) or a key press (tuser 1) and
// gives exactly one result transaction. The block has an input register and a result
// register with the update logic between them. An accepted input is held in the input
// register until the result register is free or being taken, and then its result is
// loaded there. One transaction is accepted every cycle while the output side keeps
// taking results; the regulator state (mode, thresholds, held duty and percent) is
// updated once per transaction in that single stage.
// Configuration is always accepted and must only be written while the block is idle.
module fan_speed_and_humidity_alarm_regulator_core #(
  parameter int unsigned DEFAULT_HUM_LOW    = 40,
  parameter int unsigned DEFAULT_HUM_HIGH   = 70,
  parameter int unsigned DEFAULT_TEMP_START = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: temperature[7:0], humidity[14:8], sensor_fault[15], key[19:16], zero[23:20]
  input  logic [23:0] s_axis_tdata,
  // tuser: command[0]
  input  logic        s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: fan_duty[7:0], fan_percent[14:8], buzzer_on[15], mode_now[18:16],
  //        hum_low_now[26:19], hum_high_now[34:27], temp_start_now[42:35], zero[47:43]
  output logic [47:0] m_axis_tdata,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  fsha_pkg::cfg_t    cfg;
  fsha_pkg::item_t   in_q;
  fsha_pkg::state_t  state_q, state_d;
  fsha_pkg::result_t res_d, res_q;
  logic              in_v_q, out_v_q, adv;

  assign cfg_ready_o = 1'b1;

  fsha_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  fsha_step #(
    .DEFAULT_HUM_LOW    (DEFAULT_HUM_LOW),
    .DEFAULT_HUM_HIGH   (DEFAULT_HUM_HIGH),
    .DEFAULT_TEMP_START (DEFAULT_TEMP_START)
  ) u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // stage handshake
  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.command      <= s_axis_tuser;
      in_q.temperature  <= s_axis_tdata[7:0];
      in_q.humidity     <= s_axis_tdata[14:8];
      in_q.sensor_fault <= s_axis_tdata[15];
      in_q.key          <= s_axis_tdata[19:16];
    end
  end

  // regulator state, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode       <= fsha_pkg::MODE_DISP;
      state_q.dbg        <= 1'b0;
      state_q.hum_low    <= 8'(DEFAULT_HUM_LOW);
      state_q.hum_high   <= 8'(DEFAULT_HUM_HIGH);
      state_q.temp_start <= 8'(DEFAULT_TEMP_START);
      state_q.duty       <= 8'd0;
      state_q.pct        <= 7'd0;
    end else if (in_v_q && adv) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_v_q && adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, res_q};

endmodule
